// File: sv/k_nearest_neighbor_select_defines.svh
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select_defines
// Assertion macros used by the checker file of the neighbor selector.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_NEIGHBOR_SELECT_DEFINES_SVH
`define K_NEAREST_NEIGHBOR_SELECT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define KNN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define KNN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Sizes, command codes and shared types of the neighbor selector.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int ROBOT_SLOTS    = 16;
    localparam int NEIGHBORS_KEPT = 4;
    localparam int COORD_BITS     = 16;

    localparam int CIN_BITS  = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SLOT_AW   = $clog2(ROBOT_SLOTS);
    localparam int KC_BITS   = (NEIGHBORS_KEPT > 1) ? $clog2(NEIGHBORS_KEPT) : 1;
    localparam int ID_BITS   = 16;
    localparam int POS_BITS  = 16;
    localparam int DIST_BITS = 34;
    localparam int SLOT_BITS = 4;
    localparam int RANK_BITS = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [DIST_BITS-1:0] sq_dist;
        logic [SLOT_AW-1:0]   slot;
        logic [ID_BITS-1:0]   id;
    } knn_entry_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } knn_cell_ctrl_t;

    typedef struct packed {
        logic [ID_BITS-1:0]         id;
        logic signed [CIN_BITS-1:0] x;
        logic signed [CIN_BITS-1:0] y;
    } knn_robot_t;

endpackage

// File: sv/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell
// One rank of the sorted neighbor chain: empties on clear, takes a closer
// candidate, or the entry of the rank above when the candidate lands
// higher, and shifts toward rank zero while results are read out.
// ----------------------------------------------------------------------------
module knn_cell
    import knn_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  knn_cell_ctrl_t ctrl,
    input  knn_entry_t     cand,
    input  knn_entry_t     prev_entry,
    input  logic           prev_lt,
    input  knn_entry_t     next_entry,
    output knn_entry_t     entry,
    output logic           lt
);

    knn_entry_t data_reg;
    knn_entry_t data_next;
    logic       valid_reg;

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

    assign lt = !valid_reg || (cand.sq_dist < data_reg.sq_dist);

    always_comb
    begin
        data_next = entry;
        if (ctrl.clear)
        begin
            data_next.valid = 1'b0;
        end
        else if (ctrl.shift)
        begin
            data_next = next_entry;
        end
        else if (cand.valid && lt)
        begin
            if (prev_lt)
            begin
                data_next = prev_entry;
            end
            else
            begin
                data_next = cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= data_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: sv/knn_dist.sv
// ----------------------------------------------------------------------------
// knn_dist
// Two-stage squared distance pipeline: squares of the coordinate
// differences, then their sum; drops entries that share the query's id.
// ----------------------------------------------------------------------------
module knn_dist
    import knn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               scan_valid,
    input  logic [SLOT_AW-1:0] scan_slot,
    input  knn_robot_t         scan_robot,
    input  knn_robot_t         query_robot,
    output knn_entry_t         cand
);

    localparam int DIFF_BITS = CIN_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic [DIFF_BITS-1:0]        adx;
    logic [DIFF_BITS-1:0]        ady;
    logic [SQ_BITS-1:0]          sq_x_next;
    logic [SQ_BITS-1:0]          sq_y_next;
    logic                        b_valid_next;

    logic [SQ_BITS-1:0]          sq_x_reg;
    logic [SQ_BITS-1:0]          sq_y_reg;
    logic [SLOT_AW-1:0]          b_slot_reg;
    logic [ID_BITS-1:0]          b_id_reg;
    logic                        b_valid_reg;

    logic [SUM_BITS-1:0]         sum;
    knn_entry_t                  cand_reg;
    logic                        c_valid_reg;

    assign dx = {scan_robot.x[CIN_BITS-1], scan_robot.x}
              - {query_robot.x[CIN_BITS-1], query_robot.x};
    assign dy = {scan_robot.y[CIN_BITS-1], scan_robot.y}
              - {query_robot.y[CIN_BITS-1], query_robot.y};
    assign adx = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
    assign ady = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
    assign sq_x_next = adx * adx;
    assign sq_y_next = ady * ady;
    assign b_valid_next = scan_valid && (scan_robot.id != query_robot.id);

    assign sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg         <= sq_x_next;
        sq_y_reg         <= sq_y_next;
        b_slot_reg       <= scan_slot;
        b_id_reg         <= scan_robot.id;
        cand_reg.valid   <= b_valid_reg;
        cand_reg.sq_dist <= DIST_BITS'(sum);
        cand_reg.slot    <= b_slot_reg;
        cand_reg.id      <= b_id_reg;
    end

    always_comb
    begin
        cand       = cand_reg;
        cand.valid = c_valid_reg;
    end

endmodule

// File: sv/k_nearest_neighbor_select.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select
// Robot position table with a K-nearest-neighbor query.
// ----------------------------------------------------------------------------
// A load transaction (cmd low) writes one table slot in the cycle it is
// taken and leaves busy low, so loads go at one per cycle. A query
// transaction (cmd high) holds busy through its scan, drain and emit
// states, and the next transaction is taken only once busy is low:
// the table's single read port yields one stored robot per cycle, a
// distance pipeline feeds a chain of NEIGHBORS_KEPT sorting cells, and
// the chain then shifts out one result per cycle. The NEIGHBORS_KEPT
// results come on consecutive cycles, nearest first, each marked by
// strobe for one cycle; the receiver cannot hold them off, and the final
// one may show while busy is already low.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_select
    import knn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   cmd,
    input  logic [SLOT_BITS-1:0]   slot,
    input  logic [ID_BITS-1:0]     robot_id,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    output logic                   strobe,
    output logic [RANK_BITS-1:0]   rank,
    output logic [SLOT_BITS-1:0]   neighbor_slot,
    output logic [ID_BITS-1:0]     neighbor_id,
    output logic [DIST_BITS-1:0]   distance_sq,
    output logic                   found,
    output logic                   last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [1:0]         DRAIN_LAST = 2'd2;
    localparam logic [SLOT_AW-1:0] SCAN_LAST  = SLOT_AW'(ROBOT_SLOTS - 1);
    localparam logic [KC_BITS-1:0] EMIT_LAST  = KC_BITS'(NEIGHBORS_KEPT - 1);

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [SLOT_AW-1:0] scan_cnt_reg;
    logic [SLOT_AW-1:0] scan_cnt_next;
    logic [1:0]         drain_cnt_reg;
    logic [1:0]         drain_cnt_next;
    logic [KC_BITS-1:0] emit_cnt_reg;
    logic [KC_BITS-1:0] emit_cnt_next;

    logic               accept;
    logic               in_range;
    logic [SLOT_AW-1:0] in_addr;
    logic               load_we;
    logic               query_go;

    knn_robot_t         mem [ROBOT_SLOTS];
    knn_robot_t         wr_robot;
    logic [SLOT_AW-1:0] rd_addr;
    knn_robot_t         rd_robot_reg;
    logic [SLOT_AW-1:0] rd_slot_reg;
    logic               rd_cand_reg;
    logic               rd_cand_next;

    logic [ROBOT_SLOTS-1:0] entry_valid_reg;

    logic               q_ok_reg;
    logic               q_load_reg;
    knn_robot_t         q_robot_reg;

    knn_entry_t         cand;
    knn_cell_ctrl_t     cell_ctrl;
    knn_entry_t         cell_entry   [NEIGHBORS_KEPT];
    logic               cell_lt      [NEIGHBORS_KEPT];
    knn_entry_t         cell_prev    [NEIGHBORS_KEPT];
    logic               cell_prev_lt [NEIGHBORS_KEPT];
    knn_entry_t         cell_nxt     [NEIGHBORS_KEPT];

    logic                 strobe_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic [SLOT_BITS-1:0] nslot_reg;
    logic [ID_BITS-1:0]   nid_reg;
    logic [DIST_BITS-1:0] dist_reg;
    logic                 found_reg;
    logic                 last_reg;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(slot) < 32'(ROBOT_SLOTS));
    assign in_addr  = SLOT_AW'(slot);
    assign load_we  = accept && (cmd == CMD_LOAD) && in_range;
    assign query_go = accept && (cmd == CMD_QUERY);

    assign wr_robot.id = robot_id;
    assign wr_robot.x  = pos_x[CIN_BITS-1:0];
    assign wr_robot.y  = pos_y[CIN_BITS-1:0];
    assign rd_addr     = (state_reg == ST_IDLE) ? in_addr : scan_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[in_addr] <= wr_robot;
        end
        rd_robot_reg <= mem[rd_addr];
        rd_slot_reg  <= scan_cnt_reg;
        if (q_load_reg)
        begin
            q_robot_reg <= rd_robot_reg;
        end
    end

    assign rd_cand_next = (state_reg == ST_SCAN) && entry_valid_reg[scan_cnt_reg] && q_ok_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next     = ST_DRAIN;
                    drain_cnt_next = '0;
                end
            end
            ST_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
                if (drain_cnt_reg == DRAIN_LAST)
                begin
                    state_next    = ST_EMIT;
                    emit_cnt_next = '0;
                end
            end
            ST_EMIT:
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
                if (emit_cnt_reg == EMIT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_cnt_reg    <= '0;
            drain_cnt_reg   <= '0;
            emit_cnt_reg    <= '0;
            entry_valid_reg <= '0;
            q_ok_reg        <= 1'b0;
            q_load_reg      <= 1'b0;
            rd_cand_reg     <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            if (load_we)
            begin
                entry_valid_reg[in_addr] <= 1'b1;
            end
            if (query_go)
            begin
                q_ok_reg <= in_range && entry_valid_reg[in_addr];
            end
            q_load_reg  <= query_go;
            rd_cand_reg <= rd_cand_next;
            strobe_reg  <= (state_reg == ST_EMIT);
        end
    end

    knn_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan_valid  (rd_cand_reg),
        .scan_slot   (rd_slot_reg),
        .scan_robot  (rd_robot_reg),
        .query_robot (q_robot_reg),
        .cand        (cand)
    );

    assign cell_ctrl.clear = query_go;
    assign cell_ctrl.shift = (state_reg == ST_EMIT);

    for (genvar i = 0; i < NEIGHBORS_KEPT; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_prev[i]    = '0;
            assign cell_prev_lt[i] = 1'b0;
        end
        else
        begin : g_inner
            assign cell_prev[i]    = cell_entry[i-1];
            assign cell_prev_lt[i] = cell_lt[i-1];
        end
        if (i == NEIGHBORS_KEPT - 1)
        begin : g_tail
            assign cell_nxt[i] = '0;
        end
        else
        begin : g_body
            assign cell_nxt[i] = cell_entry[i+1];
        end

        knn_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .cand       (cand),
            .prev_entry (cell_prev[i]),
            .prev_lt    (cell_prev_lt[i]),
            .next_entry (cell_nxt[i]),
            .entry      (cell_entry[i]),
            .lt         (cell_lt[i])
        );
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= RANK_BITS'(emit_cnt_reg);
        last_reg  <= (emit_cnt_reg == EMIT_LAST);
        found_reg <= cell_entry[0].valid;
        if (cell_entry[0].valid)
        begin
            nslot_reg <= SLOT_BITS'(cell_entry[0].slot);
            nid_reg   <= cell_entry[0].id;
            dist_reg  <= cell_entry[0].sq_dist;
        end
        else
        begin
            nslot_reg <= '0;
            nid_reg   <= '0;
            dist_reg  <= '0;
        end
    end

    assign strobe        = strobe_reg;
    assign rank          = rank_reg;
    assign neighbor_slot = nslot_reg;
    assign neighbor_id   = nid_reg;
    assign distance_sq   = dist_reg;
    assign found         = found_reg;
    assign last          = last_reg;

endmodule

// File: sv/knn_checker.sv
// ----------------------------------------------------------------------------
// knn_checker
// Port-level checks of the neighbor selector's query and result sequence.
// ----------------------------------------------------------------------------
`include "k_nearest_neighbor_select_defines.svh"

module knn_checker
    import knn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 cmd,
    input logic                 strobe,
    input logic [RANK_BITS-1:0] rank,
    input logic [SLOT_BITS-1:0] neighbor_slot,
    input logic [ID_BITS-1:0]   neighbor_id,
    input logic [DIST_BITS-1:0] distance_sq,
    input logic                 found,
    input logic                 last
);

    `KNN_ASSERT_NEXT(a_query_busy, start && !busy && cmd == CMD_QUERY, busy)
    `KNN_ASSERT_NEXT(a_burst, strobe && !last, strobe && rank == $past(rank) + 2'd1)
    `KNN_ASSERT_NEXT(a_burst_end, strobe && last, !strobe)
    `KNN_ASSERT_SAME(a_empty_rank, strobe && !found, distance_sq == '0 && neighbor_id == '0 && neighbor_slot == '0)
    `KNN_ASSERT_NEXT(a_found_prefix, strobe && !found && !last, !found)

endmodule

bind k_nearest_neighbor_select knn_checker u_knn_checker (.*);

// File: dv/tb_k_nearest_neighbor_select.sv
// ----------------------------------------------------------------------------
// tb_k_nearest_neighbor_select
// Self-checking testbench for the robot nearest-neighbor selector. A short
// table of load and query transactions covers empty and invalid queries,
// coordinate extremes, shared identifiers, distance ties and slot reloads.
// Random loads and queries follow. Every query is predicted from a private
// copy of the robot table and each strobed neighbor is compared field by
// field in order.
// ----------------------------------------------------------------------------
module tb_k_nearest_neighbor_select;
    import knn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 4;
    localparam int          DIRECTED_ROWS = 21;
    localparam int          RANDOM_ITEMS  = 130;
    localparam int          IDLE_PCT      = 8;
    localparam int          DRAIN_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 40;
    localparam longint      DIST_SAT      = (64'd1 << DIST_BITS) - 64'd1;
    localparam logic [DIST_BITS-1:0] CORNER_DIST = 34'd8589672450;

    typedef struct {
        logic                       cmd;
        logic [SLOT_BITS-1:0]       slot;
        logic [ID_BITS-1:0]         id;
        logic signed [POS_BITS-1:0] x;
        logic signed [POS_BITS-1:0] y;
        bit                         typed;
        logic                       t_found;
        logic [SLOT_BITS-1:0]       t_slot;
        logic [ID_BITS-1:0]         t_id;
        logic [DIST_BITS-1:0]       t_distance;
    } robot_cmd_t;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [SLOT_BITS-1:0] nslot;
        logic [ID_BITS-1:0]   nid;
        logic [DIST_BITS-1:0] distance;
        logic                 found;
        logic                 last;
    } neighbor_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       cmd;
    logic [SLOT_BITS-1:0]       slot;
    logic [ID_BITS-1:0]         robot_id;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic                       strobe;
    logic [RANK_BITS-1:0]       rank;
    logic [SLOT_BITS-1:0]       neighbor_slot;
    logic [ID_BITS-1:0]         neighbor_id;
    logic [DIST_BITS-1:0]       distance_sq;
    logic                       found;
    logic                       last;

    logic [ID_BITS-1:0]         robot_id_mem [ROBOT_SLOTS];
    logic signed [POS_BITS-1:0] robot_x_mem  [ROBOT_SLOTS];
    logic signed [POS_BITS-1:0] robot_y_mem  [ROBOT_SLOTS];
    bit                         robot_valid  [ROBOT_SLOTS];

    neighbor_t pending_neighbors[$];
    int        mismatch_count = 0;
    bit        idle_on = 1'b1;

    robot_cmd_t directed_cmds [DIRECTED_ROWS] = '{
        '{CMD_QUERY, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd15, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd0,  16'h0000, 16'h8000, 16'h8000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd15, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd15, 16'hFFFF,
          CORNER_DIST},
        '{CMD_QUERY, 4'd15, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd0,  16'h0000,
          CORNER_DIST},
        '{CMD_LOAD,  4'd1,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd15, 16'hFFFF,
          CORNER_DIST},
        '{CMD_LOAD,  4'd2,  16'h1234, 16'h0064, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd3,  16'h1235, 16'h0000, 16'h0064, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd4,  16'h1236, 16'hFF9C, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd5,  16'h1237, 16'h0000, 16'hFF9C, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd6,  16'h1238, 16'h0064, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd1,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_LOAD,  4'd7,  16'h1239, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd1,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd7,  16'h1239, 34'd2},
        '{CMD_LOAD,  4'd2,  16'h5555, 16'h0007, 16'h0007, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd2,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd9,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 4'd0,  16'h0000, 34'd0},
        '{CMD_QUERY, 4'd7,  16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 4'd0,  16'h0000, 34'd0}
    };

    k_nearest_neighbor_select i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .slot          (slot),
        .robot_id      (robot_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .strobe        (strobe),
        .rank          (rank),
        .neighbor_slot (neighbor_slot),
        .neighbor_id   (neighbor_id),
        .distance_sq   (distance_sq),
        .found         (found),
        .last          (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [DIST_BITS-1:0] planar_dist_sq(input int a, input int b);
        longint dx;
        longint dy;
        longint sum;
        dx  = longint'(robot_x_mem[a]) - longint'(robot_x_mem[b]);
        dy  = longint'(robot_y_mem[a]) - longint'(robot_y_mem[b]);
        sum = dx * dx + dy * dy;
        if (sum > DIST_SAT)
        begin
            sum = DIST_SAT;
        end
        return sum[DIST_BITS-1:0];
    endfunction

    task automatic predict_neighbors(input logic [SLOT_BITS-1:0] qslot);
        logic [DIST_BITS-1:0] kept_dist [NEIGHBORS_KEPT];
        int                   kept_slot [NEIGHBORS_KEPT];
        int                   kept = 0;
        int                   pos;
        int                   k;
        logic [DIST_BITS-1:0] d;
        neighbor_t            nb;
        if (robot_valid[qslot])
        begin
            for (int s = 0; s < ROBOT_SLOTS; s++)
            begin
                if (!robot_valid[s] || robot_id_mem[s] == robot_id_mem[qslot])
                begin
                    continue;
                end
                d = planar_dist_sq(qslot, s);
                if (kept == NEIGHBORS_KEPT && d >= kept_dist[NEIGHBORS_KEPT-1])
                begin
                    continue;
                end
                pos = 0;
                while (pos < kept && kept_dist[pos] <= d)
                begin
                    pos++;
                end
                k = (kept < NEIGHBORS_KEPT) ? kept : NEIGHBORS_KEPT - 1;
                while (k > pos)
                begin
                    kept_dist[k] = kept_dist[k-1];
                    kept_slot[k] = kept_slot[k-1];
                    k--;
                end
                kept_dist[pos] = d;
                kept_slot[pos] = s;
                if (kept < NEIGHBORS_KEPT)
                begin
                    kept++;
                end
            end
        end
        for (int r = 0; r < NEIGHBORS_KEPT; r++)
        begin
            nb.rank     = RANK_BITS'(r);
            nb.found    = (r < kept);
            nb.nslot    = nb.found ? SLOT_BITS'(kept_slot[r]) : '0;
            nb.nid      = nb.found ? robot_id_mem[kept_slot[r]] : '0;
            nb.distance = nb.found ? kept_dist[r] : '0;
            nb.last     = (r == NEIGHBORS_KEPT - 1);
            pending_neighbors.push_back(nb);
        end
    endtask

    task automatic issue(input robot_cmd_t item);
        int gap;
        int idx;
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 24);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= item.cmd;
        slot     <= item.slot;
        robot_id <= item.id;
        pos_x    <= item.x;
        pos_y    <= item.y;
        do
        begin
            @(negedge clk);
        end
        while (busy);
        @(posedge clk);
        if (item.cmd == CMD_LOAD)
        begin
            robot_id_mem[item.slot] = item.id;
            robot_x_mem[item.slot]  = item.x;
            robot_y_mem[item.slot]  = item.y;
            robot_valid[item.slot]  = 1'b1;
        end
        else
        begin
            predict_neighbors(item.slot);
            if (item.typed)
            begin
                idx = pending_neighbors.size() - NEIGHBORS_KEPT;
                pending_neighbors[idx].found    = item.t_found;
                pending_neighbors[idx].nslot    = item.t_slot;
                pending_neighbors[idx].nid      = item.t_id;
                pending_neighbors[idx].distance = item.t_distance;
            end
        end
    endtask

    function automatic logic signed [POS_BITS-1:0] rand_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            return POS_BITS'($signed($urandom_range(16)) - 8);
        end
        else if (pick < 40)
        begin
            return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        return POS_BITS'($urandom);
    endfunction

    task automatic report(input string field, input longint unsigned expv,
                          input longint unsigned actv);
        if (expv != actv)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
    begin
        neighbor_t exp_nb;
        if (rst_n && strobe)
        begin
            if (pending_neighbors.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual rank %0d slot %0d",
                         $time, rank, neighbor_slot);
                mismatch_count++;
            end
            else
            begin
                exp_nb = pending_neighbors.pop_front();
                report("rank", exp_nb.rank, rank);
                report("neighbor_slot", exp_nb.nslot, neighbor_slot);
                report("neighbor_id", exp_nb.nid, neighbor_id);
                report("distance_sq", exp_nb.distance, distance_sq);
                report("found", exp_nb.found, found);
                report("last", exp_nb.last, last);
            end
        end
    end

    initial
    begin
        robot_cmd_t item;
        int         drain;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_LOAD;
        slot     = '0;
        robot_id = '0;
        pos_x    = '0;
        pos_y    = '0;
        for (int s = 0; s < ROBOT_SLOTS; s++)
        begin
            robot_valid[s] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue(directed_cmds[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on = (i < 40 || i >= 100);
            item = directed_cmds[0];
            item.typed = 1'b0;
            item.id    = ID_BITS'($urandom);
            item.x     = POS_BITS'($urandom);
            item.y     = POS_BITS'($urandom);
            if ($urandom_range(99) < 45)
            begin
                item.cmd  = CMD_LOAD;
                item.slot = SLOT_BITS'($urandom_range(ROBOT_SLOTS - 1));
                if ($urandom_range(99) < 40)
                begin
                    item.id = 16'h00A0 + ID_BITS'($urandom_range(5));
                end
                item.x = rand_coord();
                item.y = rand_coord();
            end
            else
            begin
                item.cmd = CMD_QUERY;
                if ($urandom_range(99) < 85)
                begin
                    do
                    begin
                        item.slot = SLOT_BITS'($urandom_range(ROBOT_SLOTS - 1));
                    end
                    while (!robot_valid[item.slot]);
                end
                else
                begin
                    item.slot = SLOT_BITS'($urandom_range(ROBOT_SLOTS - 1));
                end
            end
            issue(item);
        end
        start <= 1'b0;

        for (drain = 0; drain < DRAIN_LIMIT && pending_neighbors.size() != 0; drain++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_neighbors.size() != 0)
        begin
            $display("%0t ns: missing results, expected %0d more, actual 0",
                     $time, pending_neighbors.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("k_nearest_neighbor_select verification clean");
        end
        else
        begin
            $display("k_nearest_neighbor_select verification failed");
        end
        $finish;
    end

    initial
    begin
        #500_000;
        $display("k_nearest_neighbor_select verification failed");
        $finish;
    end

endmodule
